// ===== sv/atm_pkg.sv =====
// atm_pkg: shared types, constants and helper functions of the analog to midi value mapper
// no dependencies; imported by every module of the block
package atm_pkg;

  // block sizing
  localparam int NUM_CHANNELS     = 64;
  localparam int POSITION_MAX     = 16383;
  localparam int CC14_INDEX_LIMIT = 32;

  // fixed field widths
  localparam int CHAN_W  = 6;
  localparam int POS_IN_W = 16;
  localparam int VAL_W   = 14;

  // derived widths
  localparam int CHAN_AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int POS_W   = $clog2(POSITION_MAX + 1);
  localparam int XW      = POS_W + VAL_W;
  localparam int RCP_W   = XW - POS_W + 2;
  localparam int MB_TMP  = (RCP_W > POS_W) ? RCP_W : POS_W;
  localparam int MB_W    = (MB_TMP > VAL_W) ? MB_TMP : VAL_W;
  localparam longint unsigned RECIP = (64'd1 << XW) / POSITION_MAX;

  localparam logic [VAL_W-1:0] MAX7  = VAL_W'(127);
  localparam logic [VAL_W-1:0] MAX14 = VAL_W'(16383);

  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_WRITE  = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_REPLAY = 2'd3
  } req_type_e;

  typedef enum logic [3:0] {
    KIND_CC       = 4'd0,
    KIND_NOTE     = 4'd1,
    KIND_PAD      = 4'd2,
    KIND_BUTTON   = 4'd3,
    KIND_NRPN7    = 4'd4,
    KIND_NRPN14   = 4'd5,
    KIND_PITCH    = 4'd6,
    KIND_CC14     = 4'd7,
    KIND_RESERVED = 4'd8
  } kind_e;

  typedef enum logic [2:0] {
    MK_CC       = 3'd0,
    MK_NOTE_ON  = 3'd1,
    MK_NOTE_OFF = 3'd2,
    MK_NRPN7    = 3'd3,
    MK_NRPN14   = 3'd4,
    MK_PITCH    = 3'd5,
    MK_CC14     = 3'd6,
    MK_INVALID  = 3'd7
  } midi_kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_RCP,
    S_BACK,
    S_FIN
  } state_e;

  typedef enum logic [1:0] {
    MUL_SPAN,
    MUL_RECIP,
    MUL_BACK
  } mul_op_e;

  typedef struct packed {
    logic               en;
    mul_op_e            op;
  } scale_ctrl_t;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [CHAN_W-1:0]   chan_index;
    logic [POS_IN_W-1:0] position;
    logic [3:0]          set_kind;
    logic                set_invert;
    logic [VAL_W-1:0]    set_lower;
    logic [VAL_W-1:0]    set_upper;
    logic [4:0]          set_midi_chan;
    logic [VAL_W-1:0]    set_midi_id;
  } map_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0]   comp_index;
    logic [15:0]         norm_value;
    logic [VAL_W-1:0]    norm_max;
    logic                midi_valid;
    logic [2:0]          midi_kind;
    logic [4:0]          midi_chan;
    logic [VAL_W-1:0]    midi_number;
    logic [15:0]         midi_value;
  } map_out_t;

  typedef struct packed {
    logic [3:0]       kind;
    logic             invert;
    logic [VAL_W-1:0] lower;
    logic [VAL_W-1:0] upper;
    logic [4:0]       midi_chan;
    logic [VAL_W-1:0] midi_id;
  } settings_t;

  typedef struct packed {
    logic             present;
    logic             pressed;
    logic [15:0]      value;
    logic [VAL_W-1:0] max;
  } last_t;

  localparam int SET_W  = $bits(settings_t);
  localparam int LAST_W = $bits(last_t);

  function automatic kind_e norm_kind(input logic [3:0] k);
    return (k > 4'd8) ? KIND_RESERVED : kind_e'(k);
  endfunction

  function automatic logic is_wide(input kind_e k);
    return (k == KIND_NRPN14) || (k == KIND_PITCH) || (k == KIND_CC14);
  endfunction

  function automatic midi_kind_e kind_to_midi(input kind_e k);
    midi_kind_e mk;
    case (k)
      KIND_CC:     mk = MK_CC;
      KIND_NOTE:   mk = MK_NOTE_ON;
      KIND_PAD:    mk = MK_NOTE_ON;
      KIND_NRPN7:  mk = MK_NRPN7;
      KIND_NRPN14: mk = MK_NRPN14;
      KIND_PITCH:  mk = MK_PITCH;
      KIND_CC14:   mk = MK_CC14;
      default:     mk = MK_INVALID;
    endcase
    return mk;
  endfunction

endpackage

// ===== sv/atm_ram.sv =====
// atm_ram: per-channel table with registered read and a valid bit per entry
// entries never written or cleared read as zero; uses atm_pkg
module atm_ram import atm_pkg::*; #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 4,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [AW-1:0]     rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o,
  input  logic              wr_en_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  input  logic              clr_en_i,
  input  logic [AW-1:0]     clr_addr_i
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid_q;
  logic [DATA_W-1:0] rd_data_q;

  // valid bits: clear wins over write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (clr_en_i) begin
        valid_q[clr_addr_i] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= valid_q[rd_addr_i] ? mem[rd_addr_i] : '0;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== sv/atm_scale.sv =====
// atm_scale: shared multiplier that scales a position into a limit range
// span multiply, reciprocal multiply, back multiply with correction; uses atm_pkg
module atm_scale import atm_pkg::*; (
  input  logic             clk_i,
  input  scale_ctrl_t      ctrl_i,
  input  logic [POS_W-1:0] pos_i,
  input  logic [VAL_W-1:0] lo_i,
  input  logic [VAL_W-1:0] hi_i,
  input  logic             invert_i,
  input  logic [VAL_W-1:0] mx_i,
  output logic [VAL_W-1:0] value_o
);

  logic [XW-1:0]      mul_a;
  logic [MB_W-1:0]    mul_b;
  logic [XW+MB_W-1:0] prod;
  logic               swap;
  logic [VAL_W-1:0]   span;

  logic [VAL_W-1:0]   a_q, b_q, mx_q, q0_q, q_q;
  logic               mirror_q;
  logic [XW-1:0]      x_q;
  logic               round_up;

  logic [VAL_W:0]     m_sum, m_mir, m_sel;

  assign swap = lo_i > hi_i;
  assign span = swap ? (lo_i - hi_i) : (hi_i - lo_i);

  // operand select for the one multiplier
  always_comb begin
    case (ctrl_i.op)
      MUL_SPAN: begin
        mul_a = XW'(pos_i);
        mul_b = MB_W'(span);
      end
      MUL_RECIP: begin
        mul_a = x_q;
        mul_b = MB_W'(RECIP);
      end
      MUL_BACK: begin
        mul_a = XW'(q0_q);
        mul_b = MB_W'(POSITION_MAX);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = (XW+MB_W)'(mul_a) * (XW+MB_W)'(mul_b);

  // estimate may be one low: bump when remainder reaches the divisor
  assign round_up = ({1'b0, x_q} >= ((XW+1)'(prod) + (XW+1)'(POSITION_MAX)));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      case (ctrl_i.op)
        MUL_SPAN: begin
          x_q      <= XW'(prod);
          a_q      <= swap ? hi_i : lo_i;
          b_q      <= swap ? lo_i : hi_i;
          mirror_q <= swap ^ invert_i;
          mx_q     <= mx_i;
        end
        MUL_RECIP: begin
          q0_q <= VAL_W'(prod >> XW);
        end
        MUL_BACK: begin
          q_q <= q0_q + VAL_W'(round_up);
        end
        default: begin
          q_q <= q_q;
        end
      endcase
    end
  end

  // offset, mirror, clamp
  assign m_sum = {1'b0, q_q} + {1'b0, a_q};
  assign m_mir = {1'b0, a_q} + {1'b0, b_q} - m_sum;
  assign m_sel = mirror_q ? m_mir : m_sum;
  assign value_o = (m_sel > {1'b0, mx_q}) ? mx_q : m_sel[VAL_W-1:0];

endmodule

// ===== sv/analog_to_midi_value_mapper.sv =====
// analog_to_midi_value_mapper: top level with sequencer, channel tables and result register
// uses atm_pkg, atm_ram and atm_scale
// a sample or replay item steps through S_MUL, S_RCP, S_BACK and S_FIN, and any result strobe is
//   registered out of S_FIN; busy holds a new item off through the three multiplier passes and S_FIN
// write and clear items complete in the accept cycle, busy never rises, no result
// reset: asynchronous active low, clears the sequencer, strobe and all table valid bits
// the receiver cannot stall: each result is shown for exactly one cycle
module analog_to_midi_value_mapper import atm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  input  map_in_t  item_i,
  output logic     res_strobe_o,
  output map_out_t res_o
);

  state_e state_q, state_d;

  // latched request
  logic [1:0]          req_type_q;
  logic [CHAN_W-1:0]   chan_q;
  logic [POS_IN_W-1:0] pos_q;

  logic accept, chan_ok, go;
  logic set_wr, last_clr;

  settings_t   set_rd, set_new;
  last_t       last_rd, last_wr;
  logic        last_wr_en;

  scale_ctrl_t scale_ctrl;
  logic [VAL_W-1:0] map_v;

  // decoded settings of the addressed channel
  kind_e            kind;
  midi_kind_e       kind_mk;
  logic             wide, is_button, is_pad, blocked, pos_ok, pressed;
  logic [VAL_W-1:0] lo_m, hi_m, mx, number;

  // result assembly
  logic             emit, put_midi;
  midi_kind_e       mk_sel;
  logic [15:0]      mval, nval;
  logic [VAL_W-1:0] nmax;
  map_out_t         res_d, res_q;
  logic             strobe_q;

  // handshake
  assign busy_o  = (state_q != S_IDLE);
  assign accept  = start_i && !busy_o;
  assign chan_ok = (32'(item_i.chan_index) < NUM_CHANNELS);
  assign go      = accept && chan_ok &&
                   ((item_i.req_type == REQ_SAMPLE) || (item_i.req_type == REQ_REPLAY));
  assign set_wr   = accept && chan_ok && (item_i.req_type == REQ_WRITE);
  assign last_clr = accept && chan_ok && (item_i.req_type == REQ_CLEAR);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_type_q <= item_i.req_type;
      chan_q     <= item_i.chan_index;
      pos_q      <= item_i.position;
    end
  end

  // settings table, written straight from the request
  always_comb begin
    set_new.kind      = item_i.set_kind;
    set_new.invert    = item_i.set_invert;
    set_new.lower     = item_i.set_lower;
    set_new.upper     = item_i.set_upper;
    set_new.midi_chan = item_i.set_midi_chan;
    set_new.midi_id   = item_i.set_midi_id;
  end

  atm_ram #(
    .DATA_W (SET_W),
    .DEPTH  (NUM_CHANNELS)
  ) u_set_ram (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (go),
    .rd_addr_i  (CHAN_AW'(item_i.chan_index)),
    .rd_data_o  (set_rd),
    .wr_en_i    (set_wr),
    .wr_addr_i  (CHAN_AW'(item_i.chan_index)),
    .wr_data_i  (set_new),
    .clr_en_i   (1'b0),
    .clr_addr_i (CHAN_AW'(item_i.chan_index))
  );

  // last value table; present bit reads zero for a cleared channel
  atm_ram #(
    .DATA_W (LAST_W),
    .DEPTH  (NUM_CHANNELS)
  ) u_last_ram (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (go),
    .rd_addr_i  (CHAN_AW'(item_i.chan_index)),
    .rd_data_o  (last_rd),
    .wr_en_i    (last_wr_en),
    .wr_addr_i  (CHAN_AW'(chan_q)),
    .wr_data_i  (last_wr),
    .clr_en_i   (last_clr),
    .clr_addr_i (CHAN_AW'(item_i.chan_index))
  );

  // decode; read data holds steady for the whole item
  assign kind      = norm_kind(set_rd.kind);
  assign kind_mk   = kind_to_midi(kind);
  assign wide      = is_wide(kind);
  assign is_button = (kind == KIND_BUTTON);
  assign is_pad    = (kind == KIND_PAD);
  assign lo_m      = wide ? set_rd.lower   : {{(VAL_W-7){1'b0}}, set_rd.lower[6:0]};
  assign hi_m      = wide ? set_rd.upper   : {{(VAL_W-7){1'b0}}, set_rd.upper[6:0]};
  assign number    = wide ? set_rd.midi_id : {{(VAL_W-7){1'b0}}, set_rd.midi_id[6:0]};
  assign mx        = is_button ? VAL_W'(1) : (wide ? MAX14 : MAX7);
  assign blocked   = (kind == KIND_CC14) && (number >= VAL_W'(CC14_INDEX_LIMIT));
  assign pos_ok    = (pos_q <= POS_IN_W'(POSITION_MAX));
  assign pressed   = is_pad && (map_v != '0);

  atm_scale u_scale (
    .clk_i    (clk_i),
    .ctrl_i   (scale_ctrl),
    .pos_i    (POS_W'(pos_q)),
    .lo_i     (lo_m),
    .hi_i     (hi_m),
    .invert_i (set_rd.invert),
    .mx_i     (mx),
    .value_o  (map_v)
  );

  // sequencer: next state
  always_comb begin
    case (state_q)
      S_IDLE:  state_d = go ? S_MUL : S_IDLE;
      S_MUL:   state_d = S_RCP;
      S_RCP:   state_d = S_BACK;
      S_BACK:  state_d = S_FIN;
      S_FIN:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // sequencer: multiplier control
  always_comb begin
    case (state_q)
      S_MUL:   scale_ctrl = '{en: 1'b1, op: MUL_SPAN};
      S_RCP:   scale_ctrl = '{en: 1'b1, op: MUL_RECIP};
      S_BACK:  scale_ctrl = '{en: 1'b1, op: MUL_BACK};
      default: scale_ctrl = '{en: 1'b0, op: MUL_SPAN};
    endcase
  end

  // result decision and last value update in the final step
  always_comb begin
    emit       = 1'b0;
    put_midi   = 1'b0;
    mk_sel     = kind_mk;
    mval       = '0;
    nval       = '0;
    nmax       = '0;
    last_wr_en = 1'b0;
    last_wr    = '0;
    if (state_q == S_FIN) begin
      if (req_type_q == REQ_REPLAY) begin
        // replay uses stored value with current settings
        if (last_rd.present) begin
          emit = 1'b1;
          nval = last_rd.value;
          if (is_button) begin
            nmax     = VAL_W'(1);
            put_midi = 1'b1;
            mval     = last_rd.value;
          end else begin
            nmax = last_rd.max;
            if (!blocked) begin
              put_midi = 1'b1;
              if (is_pad && !last_rd.pressed) begin
                mk_sel = MK_NOTE_OFF;
              end else begin
                mval = last_rd.value;
              end
            end
          end
        end
      end else if (is_button) begin
        // buttons pass the raw value, never suppressed
        emit            = 1'b1;
        last_wr_en      = 1'b1;
        last_wr.present = 1'b1;
        last_wr.value   = pos_q;
        last_wr.max     = VAL_W'(1);
        nval            = pos_q;
        nmax            = VAL_W'(1);
        put_midi        = 1'b1;
        mval            = pos_q;
      end else if (pos_ok) begin
        // suppress an unchanged value
        if (!(last_rd.present && (last_rd.value == 16'(map_v)) && (last_rd.max == mx))) begin
          emit            = 1'b1;
          last_wr_en      = 1'b1;
          last_wr.present = 1'b1;
          last_wr.pressed = pressed;
          last_wr.value   = 16'(map_v);
          last_wr.max     = mx;
          nval            = 16'(map_v);
          nmax            = mx;
          if (!blocked) begin
            if (!is_pad) begin
              put_midi = 1'b1;
              mval     = 16'(map_v);
            end else if (pressed) begin
              // note on only on the press edge
              put_midi = !last_rd.pressed;
              mval     = 16'(map_v);
            end else if (last_rd.pressed) begin
              put_midi = 1'b1;
              mk_sel   = MK_NOTE_OFF;
            end
          end
        end
      end
    end
  end

  // midi fields stay zero when no message goes out
  always_comb begin
    res_d             = '0;
    res_d.comp_index  = chan_q;
    res_d.norm_value  = nval;
    res_d.norm_max    = nmax;
    res_d.midi_valid  = put_midi;
    if (put_midi) begin
      res_d.midi_kind   = mk_sel;
      res_d.midi_chan   = set_rd.midi_chan;
      res_d.midi_number = number;
      res_d.midi_value  = mval;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_FIN) begin
      res_q <= res_d;
    end
  end

  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

endmodule

// ===== sv/atm_checker.sv =====
// atm_checker: port-level assertions for the analog to midi value mapper
// bound to the top level by the bind statement below; uses atm_pkg
module atm_checker import atm_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start_i,
  input logic     busy_o,
  input map_in_t  item_i,
  input logic     res_strobe_o,
  input map_out_t res_o
);

  logic accept, chan_ok;

  assign accept  = start_i && !busy_o;
  assign chan_ok = (32'(item_i.chan_index) < NUM_CHANNELS);

  // each result strobe pulse is followed by a low strobe
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |=> !res_strobe_o)
    else $error("result strobe held for two cycles");

  // a result only follows a busy cycle
  a_strobe_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> $past(busy_o))
    else $error("result without a preceding busy cycle");

  // sample and replay items occupy the block
  a_busy_on_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && chan_ok && ((item_i.req_type == REQ_SAMPLE) || (item_i.req_type == REQ_REPLAY)))
    |=> busy_o)
    else $error("sample or replay item did not raise busy");

  // table writes and clears finish at once with no result
  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && ((item_i.req_type == REQ_WRITE) || (item_i.req_type == REQ_CLEAR)))
    |=> (!busy_o && !res_strobe_o))
    else $error("write or clear item produced activity");

  // no midi message means zero midi fields
  a_midi_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && !res_o.midi_valid) |->
    ((res_o.midi_kind == 3'd0) && (res_o.midi_chan == 5'd0) &&
     (res_o.midi_number == '0) && (res_o.midi_value == 16'd0)))
    else $error("midi fields not zero without a midi message");

endmodule

bind analog_to_midi_value_mapper atm_checker u_atm_checker (.*);

// ===== tb/analog_to_midi_value_mapper_tb.sv =====
// analog_to_midi_value_mapper_tb: self-checking testbench for the analog to midi value mapper
// drives requests through the start/busy handshake and checks every result strobe against a
// table model or a directed row's outcome; depends on atm_pkg and the block's rtl only
module analog_to_midi_value_mapper_tb;
  import atm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF   = 10;
  localparam int RAND_ITEMS = 1150;
  localparam int CALM_FIRST = 400;   // random items in this window see no sender gaps
  localparam int CALM_LAST  = 600;
  localparam int SETTLE     = 12;    // leave room for stray strobes after the drain
  localparam int DRAIN_MAX  = 2000;
  localparam int LOG_MAX    = 40;
  // a raw kind code above the defined ones, must behave as reserved
  localparam logic [3:0] KIND_OUT_OF_RANGE = 4'hF;

  // one row of the directed plan: the item plus an optional hand-written outcome
  typedef struct packed {
    map_in_t  it;
    logic     pinned;
    logic     pin_hit;
    map_out_t pin_res;
  } plan_row_t;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     start_i;
  logic     busy_o;
  map_in_t  item_i;
  logic     res_strobe_o;
  map_out_t res_o;

  // hand-written outcome travelling alongside the item currently offered
  logic     pin_on;
  logic     pin_hit;
  map_out_t pin_res;

  // model state: per-channel settings and last sent value
  settings_t chan_cfg  [NUM_CHANNELS];
  last_t     chan_hist [NUM_CHANNELS];

  map_out_t  mapped_due [$];    // results still owed by the block, oldest first
  plan_row_t plan [$];

  int err_count    = 0;
  int results_seen = 0;
  int req_seen [4] = '{default: 0};

  always #(CLK_HALF) clk_i = ~clk_i;

  analog_to_midi_value_mapper dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .item_i       (item_i),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o)
  );

  // ---------------------------------------------------------------------------
  // behavioral model
  // ---------------------------------------------------------------------------

  // codes above the reserved one fold onto it
  function automatic kind_e kind_clamp(logic [3:0] raw);
    if (raw > 4'(KIND_RESERVED)) return KIND_RESERVED;
    return kind_e'(raw);
  endfunction

  function automatic bit wide_kind(kind_e k);
    return k == KIND_NRPN14 || k == KIND_PITCH || k == KIND_CC14;
  endfunction

  // top of the output range: 1 for buttons, 14 or 7 bits otherwise
  function automatic logic [13:0] full_scale(kind_e k);
    if (k == KIND_BUTTON) return 14'd1;
    return wide_kind(k) ? 14'h3FFF : 14'h007F;
  endfunction

  // 7-bit kinds only honor the low 7 bits of the index
  function automatic logic [13:0] msg_number(settings_t c);
    if (wide_kind(kind_clamp(c.kind))) return c.midi_id;
    return {7'd0, c.midi_id[6:0]};
  endfunction

  function automatic midi_kind_e midi_code(kind_e k);
    case (k)
      KIND_CC:              return MK_CC;
      KIND_NOTE, KIND_PAD:  return MK_NOTE_ON;
      KIND_NRPN7:           return MK_NRPN7;
      KIND_NRPN14:          return MK_NRPN14;
      KIND_PITCH:           return MK_PITCH;
      KIND_CC14:            return MK_CC14;
      default:              return MK_INVALID;
    endcase
  endfunction

  function automatic map_out_t with_midi(map_out_t r, settings_t c, midi_kind_e mk,
                                         logic [15:0] val);
    r.midi_valid  = 1'b1;
    r.midi_kind   = mk;
    r.midi_chan   = c.midi_chan;
    r.midi_number = msg_number(c);
    r.midi_value  = val;
    return r;
  endfunction

  // linear scale of the position into the limits, mirrored by reversed limits xor invert
  function automatic logic [15:0] mapped_level(int unsigned pos, settings_t c);
    kind_e       k;
    int unsigned lo, hi, m, top;
    k  = kind_clamp(c.kind);
    lo = c.lower;
    hi = c.upper;
    if (!wide_kind(k)) begin
      lo = lo & 32'h7F;
      hi = hi & 32'h7F;
    end
    if (lo > hi) begin
      m = (pos * (lo - hi)) / unsigned'(POSITION_MAX) + hi;
      if (!c.invert) m = hi + lo - m;
    end else begin
      m = (pos * (hi - lo)) / unsigned'(POSITION_MAX) + lo;
      if (c.invert) m = hi + lo - m;
    end
    top = full_scale(k);
    if (m > top) m = top;
    return m[15:0];
  endfunction

  // applies one accepted item to the model, tells whether a result follows and which
  function automatic void map_request(map_in_t it, output bit hit, output map_out_t res);
    settings_t   c;
    last_t       prev;
    kind_e       k;
    midi_kind_e  mk;
    logic [15:0] v;
    logic [13:0] top;
    bit          press_now, blocked;
    hit = 1'b0;
    res = '0;
    if (int'(it.chan_index) >= NUM_CHANNELS) return;
    c    = chan_cfg[it.chan_index];
    prev = chan_hist[it.chan_index];

    if (it.req_type == REQ_WRITE) begin
      c.kind      = it.set_kind;
      c.invert    = it.set_invert;
      c.lower     = it.set_lower;
      c.upper     = it.set_upper;
      c.midi_chan = it.set_midi_chan;
      c.midi_id   = it.set_midi_id;
      chan_cfg[it.chan_index] = c;
      return;
    end
    if (it.req_type == REQ_CLEAR) begin
      chan_hist[it.chan_index] = '0;
      return;
    end

    k       = kind_clamp(c.kind);
    mk      = midi_code(k);
    blocked = (k == KIND_CC14) && (msg_number(c) >= CC14_INDEX_LIMIT);
    res.comp_index = it.chan_index;

    if (it.req_type == REQ_REPLAY) begin
      if (!prev.present) return;
      hit = 1'b1;
      res.norm_value = prev.value;
      if (k == KIND_BUTTON) begin
        res.norm_max = 14'd1;
        res = with_midi(res, c, mk, prev.value);
        return;
      end
      res.norm_max = prev.max;
      if (blocked) return;
      if (k == KIND_PAD && !prev.pressed) res = with_midi(res, c, MK_NOTE_OFF, 16'd0);
      else res = with_midi(res, c, mk, prev.value);
      return;
    end

    // position sample; buttons pass the raw value and are never suppressed
    if (k == KIND_BUTTON) begin
      chan_hist[it.chan_index] = '{present: 1'b1, pressed: 1'b0, value: it.position,
                                   max: 14'd1};
      hit = 1'b1;
      res.norm_value = it.position;
      res.norm_max   = 14'd1;
      res = with_midi(res, c, mk, it.position);
      return;
    end
    if (it.position > POSITION_MAX) return;
    v         = mapped_level(it.position, c);
    top       = full_scale(k);
    press_now = (k == KIND_PAD) && (v != 16'd0);
    // unchanged value is dropped
    if (prev.present && prev.value == v && prev.max == top) return;
    chan_hist[it.chan_index] = '{present: 1'b1, pressed: press_now, value: v, max: top};
    hit = 1'b1;
    res.norm_value = v;
    res.norm_max   = top;
    if (blocked) return;
    if (k != KIND_PAD) res = with_midi(res, c, mk, v);
    else if (press_now) begin
      if (!prev.pressed) res = with_midi(res, c, mk, v);
    end else if (prev.pressed) res = with_midi(res, c, MK_NOTE_OFF, 16'd0);
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_miss(string what);
    err_count++;
    if (err_count <= LOG_MAX) $display("mismatch at %0t ns: %s", $time, what);
  endtask

  task automatic compare_map(map_out_t got, map_out_t want);
    if (got.comp_index !== want.comp_index)
      report_miss($sformatf("comp_index %0d, want %0d", got.comp_index, want.comp_index));
    if (got.norm_value !== want.norm_value)
      report_miss($sformatf("ch %0d norm_value %0d, want %0d", want.comp_index,
                            got.norm_value, want.norm_value));
    if (got.norm_max !== want.norm_max)
      report_miss($sformatf("ch %0d norm_max %0d, want %0d", want.comp_index,
                            got.norm_max, want.norm_max));
    if (got.midi_valid !== want.midi_valid)
      report_miss($sformatf("ch %0d midi_valid %0b, want %0b", want.comp_index,
                            got.midi_valid, want.midi_valid));
    if (got.midi_kind !== want.midi_kind)
      report_miss($sformatf("ch %0d midi_kind %0d, want %0d", want.comp_index,
                            got.midi_kind, want.midi_kind));
    if (got.midi_chan !== want.midi_chan)
      report_miss($sformatf("ch %0d midi_chan %0d, want %0d", want.comp_index,
                            got.midi_chan, want.midi_chan));
    if (got.midi_number !== want.midi_number)
      report_miss($sformatf("ch %0d midi_number %0d, want %0d", want.comp_index,
                            got.midi_number, want.midi_number));
    if (got.midi_value !== want.midi_value)
      report_miss($sformatf("ch %0d midi_value %0d, want %0d", want.comp_index,
                            got.midi_value, want.midi_value));
  endtask

  // everything here reads pre-edge values, the same ones the block acts on
  always @(posedge clk_i) begin : watch
    map_out_t want;
    bit       hit;
    if (rst_ni) begin
      // strobe belongs to an item accepted earlier, settle it before queuing a new one
      if (res_strobe_o) begin
        results_seen++;
        if (mapped_due.size() == 0) report_miss("result strobe with nothing outstanding");
        else begin
          want = mapped_due.pop_front();
          compare_map(res_o, want);
        end
      end
      if (start_i && !busy_o) begin
        req_seen[item_i.req_type]++;
        map_request(item_i, hit, want);
        // directed rows carry their outcome by hand, the model still tracks the state
        if (pin_on) begin
          hit  = pin_hit;
          want = pin_res;
        end
        if (hit) mapped_due.push_back(want);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  function automatic map_in_t cmd(req_type_e rq, int ch, int pos);
    map_in_t it;
    it            = '0;
    it.req_type   = rq;
    it.chan_index = 6'(ch);
    it.position   = 16'(pos);
    return it;
  endfunction

  function automatic map_in_t setup(int ch, logic [3:0] kind, bit inv, int lo, int hi,
                                    int mch, int id);
    map_in_t it;
    it               = cmd(REQ_WRITE, ch, 0);
    it.set_kind      = kind;
    it.set_invert    = inv;
    it.set_lower     = 14'(lo);
    it.set_upper     = 14'(hi);
    it.set_midi_chan = 5'(mch);
    it.set_midi_id   = 14'(id);
    return it;
  endfunction

  function automatic map_out_t outcome(int ch, int val, int top, bit mv, midi_kind_e mk,
                                       int mch, int num, int mval);
    map_out_t r;
    r.comp_index  = 6'(ch);
    r.norm_value  = 16'(val);
    r.norm_max    = 14'(top);
    r.midi_valid  = mv;
    r.midi_kind   = mk;
    r.midi_chan   = 5'(mch);
    r.midi_number = 14'(num);
    r.midi_value  = 16'(mval);
    return r;
  endfunction

  // offer one item and hold it until the block takes it
  task automatic deliver(map_in_t it, bit pinned, bit hit, map_out_t res);
    start_i <= 1'b1;
    item_i  <= it;
    pin_on  <= pinned;
    pin_hit <= hit;
    pin_res <= res;
    do @(posedge clk_i); while (busy_o);
  endtask

  // random sender gap, lands on any phase of a pass through the sequencer
  task automatic sender_gap(bit calm);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < 25) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin : stimulus
    map_in_t     it;
    logic [95:0] noise;
    int          roll, ch, mode, w;
    rst_ni  <= 1'b0;
    start_i <= 1'b0;
    item_i  <= '0;
    pin_on  <= 1'b0;
    pin_hit <= 1'b0;
    pin_res <= '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      chan_cfg[i]  = '0;
      chan_hist[i] = '0;
    end

    // directed plan; rows with a typed outcome read straight off the mapping rules
    // nothing stored yet: replay is silent, first sample of an all-zero cc channel goes out
    plan.push_back(plan_row_t'{cmd(REQ_REPLAY, 5, 0), 1'b1, 1'b0, '0});
    plan.push_back(plan_row_t'{cmd(REQ_SAMPLE, 0, 0), 1'b1, 1'b1,
                               outcome(0, 0, 127, 1'b1, MK_CC, 0, 0, 0)});
    // zero-width range maps every position to the same value, so it is suppressed
    plan.push_back(plan_row_t'{cmd(REQ_SAMPLE, 0, 16383), 1'b1, 1'b0, '0});
    // full 7-bit cc range, index masked to 7 bits
    plan.push_back(plan_row_t'{setup(1, KIND_CC, 1'b0, 0, 127, 16, 16'h3FFF), 1'b1, 1'b0, '0});
    plan.push_back(plan_row_t'{cmd(REQ_SAMPLE, 1, 16383), 1'b1, 1'b1,
                               outcome(1, 127, 127, 1'b1, MK_CC, 16, 127, 127)});
    plan.push_back(plan_row_t'{cmd(REQ_SAMPLE, 1, 0), 1'b1, 1'b1,
                               outcome(1, 0, 127, 1'b1, MK_CC, 16, 127, 0)});
    // positions past the scan range are dropped
    plan.push_back(plan_row_t'{cmd(REQ_SAMPLE, 1, 16384), 1'b1, 1'b0, '0});
    plan.push_back(plan_row_t'{cmd(REQ_SAMPLE, 1, 65535), 1'b1, 1'b0, '0});
    // button: raw value through, never suppressed, midi kind invalid
    plan.push_back(plan_row_t'{setup(2, KIND_BUTTON, 1'b0, 0, 0, 3, 5), 1'b1, 1'b0, '0});
    plan.push_back(plan_row_t'{cmd(REQ_SAMPLE, 2, 65535), 1'b1, 1'b1,
                               outcome(2, 65535, 1, 1'b1, MK_INVALID, 3, 5, 65535)});
    plan.push_back(plan_row_t'{cmd(REQ_SAMPLE, 2, 0), 1'b1, 1'b1,
                               outcome(2, 0, 1, 1'b1, MK_INVALID, 3, 5, 0)});
    plan.push_back(plan_row_t'{cmd(REQ_REPLAY, 2, 0), 1'b1, 1'b1,
                               outcome(2, 0, 1, 1'b1, MK_INVALID, 3, 5, 0)});
    // clear wipes the last value, replay goes silent again
    plan.push_back(plan_row_t'{cmd(REQ_CLEAR, 2, 0), 1'b1, 1'b0, '0});
    plan.push_back(plan_row_t'{cmd(REQ_REPLAY, 2, 0), 1'b1, 1'b0, '0});
    // pressure pad: note on when pressed, note off on release and on replay after release
    plan.push_back(plan_row_t'{setup(3, KIND_PAD, 1'b0, 0, 127, 1, 60), 1'b1, 1'b0, '0});
    plan.push_back(plan_row_t'{cmd(REQ_SAMPLE, 3, 16383), 1'b1, 1'b1,
                               outcome(3, 127, 127, 1'b1, MK_NOTE_ON, 1, 60, 127)});
    plan.push_back(plan_row_t'{cmd(REQ_SAMPLE, 3, 0), 1'b1, 1'b1,
                               outcome(3, 0, 127, 1'b1, MK_NOTE_OFF, 1, 60, 0)});
    plan.push_back(plan_row_t'{cmd(REQ_REPLAY, 3, 0), 1'b1, 1'b1,
                               outcome(3, 0, 127, 1'b1, MK_NOTE_OFF, 1, 60, 0)});
    // cc14 at the index limit: value goes out without midi
    plan.push_back(plan_row_t'{setup(4, KIND_CC14, 1'b0, 0, 16383, 2, 32), 1'b1, 1'b0, '0});
    plan.push_back(plan_row_t'{cmd(REQ_SAMPLE, 4, 16383), 1'b1, 1'b1,
                               outcome(4, 16383, 16383, 1'b0, MK_CC, 0, 0, 0)});
    // cc14 just under the limit, inverted full range
    plan.push_back(plan_row_t'{setup(5, KIND_CC14, 1'b1, 0, 16383, 16, 31), 1'b1, 1'b0, '0});
    plan.push_back(plan_row_t'{cmd(REQ_SAMPLE, 5, 0), 1'b1, 1'b1,
                               outcome(5, 16383, 16383, 1'b1, MK_CC14, 16, 31, 16383)});
    // out-of-range kind code acts as reserved; reversed limits mirror, limits masked to 7 bits
    plan.push_back(plan_row_t'{setup(6, KIND_OUT_OF_RANGE, 1'b0, 16'h3FFF, 0, 7, 16'h3FAA),
                               1'b1, 1'b0, '0});
    plan.push_back(plan_row_t'{cmd(REQ_SAMPLE, 6, 0), 1'b1, 1'b1,
                               outcome(6, 127, 127, 1'b1, MK_INVALID, 7, 42, 127)});
    plan.push_back(plan_row_t'{cmd(REQ_SAMPLE, 6, 8000), 1'b0, 1'b0, '0});
    // reversed 14-bit limits together with invert
    plan.push_back(plan_row_t'{setup(7, KIND_NRPN14, 1'b1, 16383, 100, 9, 16'h2345),
                               1'b1, 1'b0, '0});
    plan.push_back(plan_row_t'{cmd(REQ_SAMPLE, 7, 5000), 1'b0, 1'b0, '0});

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      deliver(plan[i].it, plan[i].pinned, plan[i].pin_hit, plan[i].pin_res);
      sender_gap(1'b0);
    end

    // random part: mostly a small pool of channels so settings, samples, replays and
    // clears keep hitting the same entries; the rest spreads over all channels
    for (int n = 0; n < RAND_ITEMS; n++) begin
      noise = {$urandom, $urandom, $urandom};
      it    = noise[$bits(map_in_t)-1:0];
      roll  = $urandom_range(0, 99);
      ch    = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 7)
                                         : $urandom_range(0, NUM_CHANNELS - 1);
      it.chan_index = 6'(ch);
      if (roll < 15) begin
        it.req_type = REQ_WRITE;
        it.set_kind = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, 8))
                                                 : 4'($urandom_range(9, 15));
        mode = $urandom_range(0, 3);
        case (mode)
          0: begin
            it.set_lower = 14'($urandom_range(0, 16383));
            it.set_upper = 14'($urandom_range(0, 16383));
          end
          1: begin
            // zero floor lets pads release
            it.set_lower = '0;
            it.set_upper = 14'($urandom_range(0, 16383));
          end
          2: begin
            it.set_lower = 14'($urandom_range(0, 16383));
            it.set_upper = '0;
          end
          default: begin
            it.set_lower = 14'($urandom_range(0, 127));
            it.set_upper = 14'($urandom_range(0, 127));
          end
        endcase
        // small indices straddle the cc14 limit
        if ($urandom_range(0, 1) == 0) it.set_midi_id = 14'($urandom_range(0, 63));
      end else if (roll < 78) begin
        it.req_type = REQ_SAMPLE;
        mode = $urandom_range(0, 9);
        case (mode)
          0:       it.position = 16'($urandom_range(POSITION_MAX + 1, 65535));
          1:       it.position = '0;
          2:       it.position = 16'(POSITION_MAX);
          3:       it.position = 16'($urandom_range(0, 3) * 5461);  // repeats get suppressed
          default: it.position = 16'($urandom_range(0, POSITION_MAX));
        endcase
      end else if (roll < 91) it.req_type = REQ_REPLAY;
      else it.req_type = REQ_CLEAR;
      deliver(it, 1'b0, 1'b0, '0);
      sender_gap(n >= CALM_FIRST && n < CALM_LAST);
    end
    start_i <= 1'b0;

    // wait for outstanding results, then the SETTLE window for anything unexpected
    w = 0;
    while (mapped_due.size() != 0 && w < DRAIN_MAX) begin
      @(posedge clk_i);
      w++;
    end
    if (mapped_due.size() != 0)
      report_miss($sformatf("%0d results never arrived", mapped_due.size()));
    repeat (SETTLE) @(posedge clk_i);

    $display("covered %0d samples, %0d setting writes, %0d clears, %0d replays",
             req_seen[REQ_SAMPLE], req_seen[REQ_WRITE], req_seen[REQ_CLEAR],
             req_seen[REQ_REPLAY]);
    $display("%0d result strobes compared, %0d mismatches", results_seen, err_count);
    if (err_count == 0) begin
      $display("analog_to_midi_value_mapper verification clean");
    end else begin
      $display("analog_to_midi_value_mapper verification failed");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin : watchdog
    #4_000_000;
    $display("analog_to_midi_value_mapper verification failed");
    $finish;
  end

endmodule
